// ===== src/ecs_pkg.sv =====
// ----------------------------------------------------------------------------
// ecs_pkg: shared definitions for the ellipse column span unit
// Default sizes, the root precision and the configuration register map.
// ----------------------------------------------------------------------------
package ecs_pkg;

  // Default field sizes of the ellipse geometry and of screen coordinates.
  localparam int SIZE_BITS_DEF  = 8;
  localparam int COORD_BITS_DEF = 16;

  // Number of fraction bits kept by the square root.
  localparam int ROOT_FRAC = 8;

  // Width of the configuration register index.
  localparam int CFG_IDX_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WIDTH      = 3'd0,
    CFG_HEIGHT     = 3'd1,
    CFG_CENTRE_COL = 3'd2,
    CFG_CENTRE_ROW = 3'd3,
    CFG_ROW_OFFSET = 3'd4
  } cfg_idx_t;

endpackage

// ===== src/ellipse_column_span_unit.sv =====
// ----------------------------------------------------------------------------
// ellipse_column_span_unit: vertical span of one column of a filled ellipse
// Takes a column index and returns the screen column and the top and
// bottom rows of the filled span in that column.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Handshake             Payload
//   in_       input      in_valid / in_stall   in_column_index
//   out_      output     out_valid / out_stall out_span_valid, out_screen_col,
//                                              out_half_span, out_top_row,
//                                              out_bottom_row
//   cfg_      input      cfg_wr_en             cfg_index, cfg_wdata
//
// One request is accepted per clock while in_stall is low; each result passes
// the front stage, the SIZE_BITS+8 root cells, the scale stage, the SIZE_BITS
// divider cells and the output register, in that order.
// Reset clears every valid flag and loads the register defaults; there is no
// clearing pass, so the unit takes requests in the first cycle after reset.
// Every stage holds its request only while the stage after it is full and
// stalled, so bubbles close up and the chain keeps filling while a finished
// result waits at the output.
// ----------------------------------------------------------------------------
module ellipse_column_span_unit #(
  parameter int SIZE_BITS  = ecs_pkg::SIZE_BITS_DEF,
  parameter int COORD_BITS = ecs_pkg::COORD_BITS_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  // Configuration write port.
  input  logic                                   cfg_wr_en,
  input  logic [ecs_pkg::CFG_IDX_W-1:0]          cfg_index,
  input  logic [((SIZE_BITS > COORD_BITS-1) ? SIZE_BITS : COORD_BITS-1)-1:0]
                                                 cfg_wdata,
  // Request channel.
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic [SIZE_BITS-1:0]                   in_column_index,
  // Result channel.
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic                                   out_span_valid,
  output logic signed [COORD_BITS:0]             out_screen_col,
  output logic [SIZE_BITS-1:0]                   out_half_span,
  output logic signed [COORD_BITS+1:0]           out_top_row,
  output logic signed [COORD_BITS+1:0]           out_bottom_row
);
  import ecs_pkg::*;

  localparam int S    = SIZE_BITS;
  localparam int PW   = COORD_BITS - 1;        // centre and offset registers
  localparam int RB   = S + ROOT_FRAC;         // root bits, one cell each
  localparam int RW   = RB + 1;                // root remainder width
  localparam int NW   = 2 * S;                 // radicand width
  localparam int NUMW = 2 * S + ROOT_FRAC;     // height times root
  localparam int XW   = ((S > COORD_BITS) ? S : COORD_BITS) + 3;

  // --------------------------------------------------------------------------
  // Configuration registers. Writes must only arrive while the unit is idle;
  // the block does not enforce this. Every stage reads these registers directly.
  // --------------------------------------------------------------------------
  logic [S-1:0]  width_r;
  logic [S-1:0]  height_r;
  logic [PW-1:0] centre_col_r;
  logic [PW-1:0] centre_row_r;
  logic [PW-1:0] row_offset_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r      <= S'(1);
      height_r     <= S'(1);
      centre_col_r <= PW'(1);
      centre_row_r <= PW'(1);
      row_offset_r <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_WIDTH:      width_r      <= cfg_wdata[S-1:0];
        CFG_HEIGHT:     height_r     <= cfg_wdata[S-1:0];
        CFG_CENTRE_COL: centre_col_r <= cfg_wdata[PW-1:0];
        CFG_CENTRE_ROW: centre_row_r <= cfg_wdata[PW-1:0];
        CFG_ROW_OFFSET: row_offset_r <= cfg_wdata[PW-1:0];
        default: begin
        end
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Front stage: offset from the centre column and the radicand
  // v = width^2 - 4*dx^2, clamped at zero for columns outside the ellipse.
  // --------------------------------------------------------------------------
  logic                  fr_valid_r;
  logic                  fr_ok_r;
  logic signed [S:0]     fr_dx_r;
  logic [NW-1:0]         fr_rad_r;
  logic                  fr_ready;

  logic                  col_ok;
  logic signed [S:0]     dx;
  logic [S-1:0]          adx;
  logic [NW-1:0]         w2;
  logic [NW+1:0]         d2;
  logic [NW+1:0]         w2_ext;
  logic [NW-1:0]         rad;

  // Ready chains run from the output back to the request port.
  logic [RB:0]           rt_valid;
  logic [RB:0]           rt_ready;
  logic [RB:0]           rt_ok;
  logic signed [S:0]     rt_dx   [RB+1];
  logic [NW-1:0]         rt_rad  [RB+1];
  logic [RW-1:0]         rt_rem  [RB+1];
  logic [RB-1:0]         rt_root [RB+1];

  always_comb begin
    col_ok = (in_column_index < width_r);
    dx     = $signed({1'b0, in_column_index}) - $signed({2'b00, width_r[S-1:1]});
    adx    = dx[S] ? S'(-dx) : dx[S-1:0];
    w2     = NW'(width_r) * NW'(width_r);
    d2     = {NW'(adx) * NW'(adx), 2'b00};
    w2_ext = (NW+2)'(w2);
    rad    = (w2_ext > d2) ? NW'(w2_ext - d2) : '0;
  end

  assign fr_ready = !fr_valid_r || rt_ready[0];
  assign in_stall = !fr_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fr_valid_r <= 1'b0;
    end else if (fr_ready) begin
      fr_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fr_ready && in_valid) begin
      fr_ok_r  <= col_ok;
      fr_dx_r  <= dx;
      fr_rad_r <= rad;
    end
  end

  // --------------------------------------------------------------------------
  // Square root chain: floor(sqrt(v * 2^(2*ROOT_FRAC))), one bit per cell.
  // The radicand is carried unshifted; zeros enter behind it as the cells
  // consume it, which supplies the fraction bits.
  // --------------------------------------------------------------------------
  assign rt_valid[0] = fr_valid_r;
  assign rt_ok[0]    = fr_ok_r;
  assign rt_dx[0]    = fr_dx_r;
  assign rt_rad[0]   = fr_rad_r;
  assign rt_rem[0]   = '0;
  assign rt_root[0]  = '0;

  logic m_ready;
  assign rt_ready[RB] = m_ready;

  for (genvar k = 0; k < RB; k++) begin : g_root
    ecs_root_cell #(
      .SIZE_BITS (SIZE_BITS)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .up_valid (rt_valid[k]),
      .up_ready (rt_ready[k]),
      .dn_valid (rt_valid[k+1]),
      .dn_ready (rt_ready[k+1]),
      .ok_i     (rt_ok[k]),
      .dx_i     (rt_dx[k]),
      .rad_i    (rt_rad[k]),
      .rem_i    (rt_rem[k]),
      .root_i   (rt_root[k]),
      .ok_o     (rt_ok[k+1]),
      .dx_o     (rt_dx[k+1]),
      .rad_o    (rt_rad[k+1]),
      .rem_o    (rt_rem[k+1]),
      .root_o   (rt_root[k+1])
    );
  end

  // --------------------------------------------------------------------------
  // Scale stage: num = height * root.
  // --------------------------------------------------------------------------
  logic               m_valid_r;
  logic               m_ok_r;
  logic signed [S:0]  m_dx_r;
  logic [NUMW-1:0]    m_num_r;

  logic [S:0]         dv_valid;
  logic [S:0]         dv_ready;
  logic [S:0]         dv_ok;
  logic signed [S:0]  dv_dx  [S+1];
  logic [S-1:0]       dv_rem [S+1];
  logic [S-1:0]       dv_low [S+1];

  assign m_ready = !m_valid_r || dv_ready[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_valid_r <= 1'b0;
    end else if (m_ready) begin
      m_valid_r <= rt_valid[RB];
    end
  end

  always_ff @(posedge clk) begin
    if (m_ready && rt_valid[RB]) begin
      m_ok_r  <= rt_ok[RB];
      m_dx_r  <= rt_dx[RB];
      m_num_r <= NUMW'(height_r) * NUMW'(rt_root[RB]);
    end
  end

  // --------------------------------------------------------------------------
  // Rounded division: h = floor((2*num + D) / (2*D)) with D = width * 2^9,
  // which equals floor(((num + width*2^8) >> 9) / width). The half height
  // never reaches 2^SIZE_BITS, so the upper half of the shifted dividend is
  // already below the width and SIZE_BITS divider cells suffice.
  // --------------------------------------------------------------------------
  logic [NUMW:0]  rnd_sum;
  logic [NW-1:0]  dvd;

  always_comb begin
    rnd_sum = (NUMW+1)'(m_num_r) + ((NUMW+1)'(width_r) << ROOT_FRAC);
    dvd     = rnd_sum[NUMW -: NW];
  end

  assign dv_valid[0] = m_valid_r;
  assign dv_ok[0]    = m_ok_r;
  assign dv_dx[0]    = m_dx_r;
  assign dv_rem[0]   = dvd[NW-1:S];
  assign dv_low[0]   = dvd[S-1:0];

  logic o_ready;
  assign dv_ready[S] = o_ready;

  for (genvar j = 0; j < S; j++) begin : g_div
    ecs_div_cell #(
      .SIZE_BITS (SIZE_BITS)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .up_valid (dv_valid[j]),
      .up_ready (dv_ready[j]),
      .dn_valid (dv_valid[j+1]),
      .dn_ready (dv_ready[j+1]),
      .divisor  (width_r),
      .ok_i     (dv_ok[j]),
      .dx_i     (dv_dx[j]),
      .rem_i    (dv_rem[j]),
      .low_i    (dv_low[j]),
      .ok_o     (dv_ok[j+1]),
      .dx_o     (dv_dx[j+1]),
      .rem_o    (dv_rem[j+1]),
      .low_o    (dv_low[j+1])
    );
  end

  // --------------------------------------------------------------------------
  // Output register: screen column and span rows. A column outside the
  // ellipse reports zero in every field.
  // --------------------------------------------------------------------------
  logic                       out_valid_r;
  logic                       out_span_valid_r;
  logic [COORD_BITS:0]        out_screen_col_r;
  logic [S-1:0]               out_half_span_r;
  logic [COORD_BITS+1:0]      out_top_row_r;
  logic [COORD_BITS+1:0]      out_bottom_row_r;

  logic [XW-1:0]              col_sum;
  logic [XW-1:0]              row_base;
  logic [XW-1:0]              top_sum;
  logic [XW-1:0]              bot_sum;
  logic [S-1:0]               h;

  always_comb begin
    h        = dv_low[S];
    col_sum  = XW'(centre_col_r) + XW'(dv_dx[S]);
    row_base = XW'(centre_row_r) + XW'(row_offset_r);
    top_sum  = row_base - XW'(h);
    bot_sum  = row_base + XW'(h);
  end

  assign o_ready = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (o_ready) begin
      out_valid_r <= dv_valid[S];
    end
  end

  always_ff @(posedge clk) begin
    if (o_ready && dv_valid[S]) begin
      out_span_valid_r <= dv_ok[S];
      if (dv_ok[S]) begin
        out_screen_col_r <= col_sum[COORD_BITS:0];
        out_half_span_r  <= h;
        out_top_row_r    <= top_sum[COORD_BITS+1:0];
        out_bottom_row_r <= bot_sum[COORD_BITS+1:0];
      end else begin
        out_screen_col_r <= '0;
        out_half_span_r  <= '0;
        out_top_row_r    <= '0;
        out_bottom_row_r <= '0;
      end
    end
  end

  assign out_valid      = out_valid_r;
  assign out_span_valid = out_span_valid_r;
  assign out_screen_col = out_screen_col_r;
  assign out_half_span  = out_half_span_r;
  assign out_top_row    = out_top_row_r;
  assign out_bottom_row = out_bottom_row_r;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  logic [COORD_BITS+1:0] span_len;
  logic [RW-1:0]         root_bound;

  assign span_len   = out_bottom_row_r - out_top_row_r;
  assign root_bound = RW'(width_r) << ROOT_FRAC;

  // Reset empties the output register.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid_r)
    else $error("result pending right after reset");

  // A span in the ellipse is symmetric about the centre row.
  a_span_sym: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_span_valid_r) |->
      (span_len == ((COORD_BITS+2)'(out_half_span_r) << 1)))
    else $error("span rows not symmetric about the centre");

  // A column outside the ellipse carries zero fields.
  a_outside_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_span_valid_r) |->
      (out_half_span_r == '0 && out_top_row_r == '0 &&
       out_bottom_row_r == '0 && out_screen_col_r == '0))
    else $error("outside column with nonzero fields");

  // The root of width^2 - 4*dx^2 never exceeds the width.
  a_root_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (rt_valid[RB] && rt_ok[RB]) |-> (RW'(rt_root[RB]) <= root_bound))
    else $error("square root above the width");

  // The divider remainder always stays below the divisor.
  a_div_rem: assert property (@(posedge clk) disable iff (!rst_n)
    (dv_valid[S] && dv_ok[S]) |-> (dv_rem[S] < width_r))
    else $error("divider remainder not below the width");

endmodule

// ===== src/ecs_root_cell.sv =====
// ----------------------------------------------------------------------------
// ecs_root_cell: one digit step of the integer square root
// Settles one root bit per cell and hands the partial root, the remainder
// and the unused radicand bits to the next cell.
// ----------------------------------------------------------------------------
module ecs_root_cell #(
  parameter int SIZE_BITS = 8
) (
  input  logic                                     clk,
  input  logic                                     rst_n,
  input  logic                                     up_valid,
  output logic                                     up_ready,
  output logic                                     dn_valid,
  input  logic                                     dn_ready,
  input  logic                                     ok_i,
  input  logic signed [SIZE_BITS:0]                dx_i,
  input  logic [2*SIZE_BITS-1:0]                   rad_i,
  input  logic [SIZE_BITS+ecs_pkg::ROOT_FRAC:0]    rem_i,
  input  logic [SIZE_BITS+ecs_pkg::ROOT_FRAC-1:0]  root_i,
  output logic                                     ok_o,
  output logic signed [SIZE_BITS:0]                dx_o,
  output logic [2*SIZE_BITS-1:0]                   rad_o,
  output logic [SIZE_BITS+ecs_pkg::ROOT_FRAC:0]    rem_o,
  output logic [SIZE_BITS+ecs_pkg::ROOT_FRAC-1:0]  root_o
);
  import ecs_pkg::*;

  localparam int RB = SIZE_BITS + ROOT_FRAC;
  localparam int RW = RB + 1;
  localparam int NW = 2 * SIZE_BITS;
  localparam int TW = RW + 2;

  logic                    valid_r;
  logic                    ok_r;
  logic signed [SIZE_BITS:0] dx_r;
  logic [NW-1:0]           rad_r, rad_nxt;
  logic [RW-1:0]           rem_r, rem_nxt;
  logic [RB-1:0]           root_r, root_nxt;
  logic [TW-1:0]           cur;
  logic [TW-1:0]           trial;
  logic                    ge;

  // Bring down the next two radicand bits and try the bit 01 after the root.
  always_comb begin
    cur      = {rem_i, rad_i[NW-1 -: 2]};
    trial    = TW'({root_i, 2'b01});
    ge       = (cur >= trial);
    rem_nxt  = ge ? RW'(cur - trial) : RW'(cur);
    root_nxt = {root_i[RB-2:0], ge};
    rad_nxt  = {rad_i[NW-3:0], 2'b00};
  end

  assign up_ready = !valid_r || dn_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      ok_r   <= ok_i;
      dx_r   <= dx_i;
      rad_r  <= rad_nxt;
      rem_r  <= rem_nxt;
      root_r <= root_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign ok_o     = ok_r;
  assign dx_o     = dx_r;
  assign rad_o    = rad_r;
  assign rem_o    = rem_r;
  assign root_o   = root_r;

endmodule

// ===== src/ecs_div_cell.sv =====
// ----------------------------------------------------------------------------
// ecs_div_cell: one step of the restoring divider
// Shifts one dividend bit into the partial remainder, subtracts the
// divisor when it fits and shifts the quotient bit into the low word.
// ----------------------------------------------------------------------------
module ecs_div_cell #(
  parameter int SIZE_BITS = 8
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      up_valid,
  output logic                      up_ready,
  output logic                      dn_valid,
  input  logic                      dn_ready,
  input  logic [SIZE_BITS-1:0]      divisor,
  input  logic                      ok_i,
  input  logic signed [SIZE_BITS:0] dx_i,
  input  logic [SIZE_BITS-1:0]      rem_i,
  input  logic [SIZE_BITS-1:0]      low_i,
  output logic                      ok_o,
  output logic signed [SIZE_BITS:0] dx_o,
  output logic [SIZE_BITS-1:0]      rem_o,
  output logic [SIZE_BITS-1:0]      low_o
);

  logic                      valid_r;
  logic                      ok_r;
  logic signed [SIZE_BITS:0] dx_r;
  logic [SIZE_BITS-1:0]      rem_r, rem_nxt;
  logic [SIZE_BITS-1:0]      low_r, low_nxt;
  logic [SIZE_BITS:0]        cur;
  logic [SIZE_BITS:0]        diff;
  logic                      ge;

  // The remainder stays below the divisor, so the difference fits the
  // remainder width whenever the subtraction is taken.
  always_comb begin
    cur     = {rem_i, low_i[SIZE_BITS-1]};
    diff    = cur - {1'b0, divisor};
    ge      = (cur >= {1'b0, divisor});
    rem_nxt = ge ? diff[SIZE_BITS-1:0] : cur[SIZE_BITS-1:0];
    low_nxt = {low_i[SIZE_BITS-2:0], ge};
  end

  assign up_ready = !valid_r || dn_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      ok_r  <= ok_i;
      dx_r  <= dx_i;
      rem_r <= rem_nxt;
      low_r <= low_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign ok_o     = ok_r;
  assign dx_o     = dx_r;
  assign rem_o    = rem_r;
  assign low_o    = low_r;

endmodule
